@@ rtl/core/lcs_pkg.sv @@
`default_nettype none

package lcs_pkg;

    localparam int PIX_W      = 8;
    localparam int CFG_W      = 12;
    localparam int CFG_IDX_W  = 2;
    localparam int STATUS_W   = 2;
    localparam int POS_W      = 18;
    localparam int ANGLE_W    = 16;
    localparam int SPEED_W    = 16;

    localparam logic [CFG_W-1:0] SPEED_GAIN_RST   = 12'd1280;
    localparam logic [CFG_W-1:0] STEER_P_GAIN_RST = 12'd256;
    localparam logic [CFG_W-1:0] STEER_D_GAIN_RST = 12'd0;
    localparam logic [CFG_W-1:0] BASE_SPEED_RST   = 12'd512;

    typedef enum logic [STATUS_W-1:0] {
        ST_DRIVE = 2'd0,
        ST_LOST  = 2'd1,
        ST_STOP  = 2'd2
    } status_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SPEED_GAIN   = 2'd0,
        REG_STEER_P_GAIN = 2'd1,
        REG_STEER_D_GAIN = 2'd2,
        REG_BASE_SPEED   = 2'd3
    } cfg_reg_t;

    typedef struct packed {
        logic [CFG_W-1:0] speed_gain;
        logic [CFG_W-1:0] steer_p_gain;
        logic [CFG_W-1:0] steer_d_gain;
        logic [CFG_W-1:0] base_speed;
    } gains_t;

    typedef enum logic [3:0] {
        BS_IDLE,
        BS_PREP1,
        BS_PREP2,
        BS_CHECK,
        BS_DIV_POS,
        BS_DIV_FRAC,
        BS_MUL,
        BS_SUM,
        BS_PUSH
    } back_state_t;

endpackage

`default_nettype wire

@@ rtl/core/lcs_fifo.sv @@
`default_nettype none

module lcs_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             wr_en,
    input  wire logic [WIDTH-1:0] wr_data,
    output logic                  full,
    input  wire logic             rd_en,
    output logic [WIDTH-1:0]      rd_data,
    output logic                  empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg;
    logic [AW-1:0]    rd_ptr_reg;
    logic [AW:0]      count_reg;
    logic             do_wr;
    logic             do_rd;

    assign full    = (count_reg == (AW+1)'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_wr)
            begin
                wr_ptr_reg <= (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_rd)
            begin
                rd_ptr_reg <= (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_wr && !do_rd)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_rd && !do_wr)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/lcs_front.sv @@
`default_nettype none

module lcs_front #(
    parameter int MAX_WIDTH = 1024
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          accept,
    input  wire logic [lcs_pkg::PIX_W-1:0]     pixel,
    input  wire logic                          last_in_row,
    output logic                               row_push,
    output logic [lcs_pkg::PIX_W + $clog2(MAX_WIDTH+1) + 2*lcs_pkg::PIX_W
                  + 3*$clog2(MAX_WIDTH) - 2:0] row_data
);
    import lcs_pkg::*;

    localparam int LG     = $clog2(MAX_WIDTH);
    localparam int CW     = $clog2(MAX_WIDTH + 1);
    localparam int SUM_W  = PIX_W + LG;
    localparam int WSUM_W = PIX_W + 2*LG - 1;

    logic [CW-1:0]     count_reg;
    logic [PIX_W-1:0]  max_reg;
    logic [SUM_W-1:0]  sum_reg;
    logic [WSUM_W-1:0] wsum_reg;

    logic              take;
    logic [CW-1:0]     count_next;
    logic [PIX_W-1:0]  max_next;
    logic [SUM_W-1:0]  sum_next;
    logic [WSUM_W-1:0] wsum_next;

    // pixels past MAX_WIDTH in one row are dropped
    always_comb
    begin
        take       = (count_reg < CW'(MAX_WIDTH));
        count_next = count_reg;
        max_next   = max_reg;
        sum_next   = sum_reg;
        wsum_next  = wsum_reg;
        if (take)
        begin
            count_next = count_reg + 1'b1;
            max_next   = (pixel > max_reg) ? pixel : max_reg;
            sum_next   = sum_reg + SUM_W'(pixel);
            wsum_next  = wsum_reg + WSUM_W'(pixel) * WSUM_W'(count_reg);
        end
    end

    assign row_push = accept && last_in_row;
    assign row_data = {count_next, max_next, sum_next, wsum_next};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            max_reg   <= '0;
            sum_reg   <= '0;
            wsum_reg  <= '0;
        end
        else if (accept)
        begin
            if (last_in_row)
            begin
                count_reg <= '0;
                max_reg   <= '0;
                sum_reg   <= '0;
                wsum_reg  <= '0;
            end
            else
            begin
                count_reg <= count_next;
                max_reg   <= max_next;
                sum_reg   <= sum_next;
                wsum_reg  <= wsum_next;
            end
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/lcs_div.sv @@
`default_nettype none

module lcs_div #(
    parameter int DVD_W = 35,
    parameter int DSR_W = 29
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic [DVD_W-1:0] dividend,
    input  wire logic [DSR_W-1:0] divisor,
    output logic                  done,
    output logic [DVD_W-1:0]      quotient
);

    localparam int CNT_W = $clog2(DVD_W + 1);

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [DSR_W-1:0] rem_reg;
    logic [DVD_W-1:0] quo_reg;
    logic [DSR_W-1:0] dsr_reg;

    logic [DSR_W:0]   trial;
    logic [DSR_W:0]   diff;
    logic             ge;
    logic [DSR_W-1:0] rem_step;

    // restoring division, one quotient bit per cycle, msb first
    always_comb
    begin
        trial    = {rem_reg, quo_reg[DVD_W-1]};
        ge       = (trial >= {1'b0, dsr_reg});
        diff     = trial - {1'b0, dsr_reg};
        rem_step = ge ? diff[DSR_W-1:0] : trial[DSR_W-1:0];
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(DVD_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dsr_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_step;
            quo_reg <= {quo_reg[DVD_W-2:0], ge};
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/lcs_back.sv @@
`default_nettype none

module lcs_back #(
    parameter int MAX_WIDTH = 1024,
    parameter int FRAC_BITS = 8
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire lcs_pkg::gains_t               gains,
    input  wire logic                          row_valid,
    input  wire logic [lcs_pkg::PIX_W + $clog2(MAX_WIDTH+1) + 2*lcs_pkg::PIX_W
                       + 3*$clog2(MAX_WIDTH) - 2:0] row_data,
    output logic                               row_pop,
    input  wire logic                          out_full,
    output logic                               out_push,
    output logic [lcs_pkg::STATUS_W + lcs_pkg::POS_W + lcs_pkg::ANGLE_W
                  + lcs_pkg::SPEED_W - 1:0]    out_data
);
    import lcs_pkg::*;

    localparam int LG      = $clog2(MAX_WIDTH);
    localparam int CW      = $clog2(MAX_WIDTH + 1);
    localparam int SUM_W   = PIX_W + LG;
    localparam int WSUM_W  = PIX_W + 2*LG - 1;
    localparam int TRI_W   = 2*LG - 1;
    localparam int TRIP_W  = 2*CW;
    localparam int T1_W    = PIX_W + CW;
    localparam int DN_W    = SUM_W + CW;
    localparam int DVD_W   = WSUM_W + FRAC_BITS;
    localparam int PROP_W  = FRAC_BITS + 1;
    localparam int DER_W   = PROP_W + 1;
    localparam int PRODP_W = CFG_W + 1 + PROP_W;
    localparam int PRODD_W = CFG_W + 1 + DER_W;
    localparam int STEER_W = PRODD_W + 1;
    localparam int SPD_W   = CFG_W + PROP_W;

    localparam logic [PROP_W-1:0]  HALF      = PROP_W'(1) << (FRAC_BITS - 1);
    localparam logic [POS_W-1:0]   POS_MAX   = '1;
    localparam logic [STEER_W-1:0] STEER_HI  = STEER_W'(32767);
    localparam logic [STEER_W-1:0] STEER_LO  = STEER_W'(-32768);
    localparam logic [SPD_W:0]     SPEED_HI  = (SPD_W+1)'(65535);

    back_state_t state_reg;
    back_state_t state_next;

    logic [CW-1:0]      n_reg;
    logic [PIX_W-1:0]   mx_reg;
    logic [SUM_W-1:0]   sum_reg;
    logic [WSUM_W-1:0]  wsum_reg;
    logic [T1_W-1:0]    t1_reg;
    logic [TRI_W-1:0]   tri_reg;
    logic [SUM_W-1:0]   den_reg;
    logic [WSUM_W-1:0]  num_reg;
    logic [DN_W-1:0]    dn_reg;

    logic signed [PROP_W-1:0]  prop_reg;
    logic signed [PROP_W-1:0]  prev_prop_reg;
    logic                      lost_reg;
    logic                      stopped_reg;
    logic signed [PRODP_W-1:0] prod_p_reg;
    logic signed [PRODD_W-1:0] prod_d_reg;
    logic [SPD_W-1:0]          prod_s_reg;

    status_t                   res_status_reg;
    logic [POS_W-1:0]          res_pos_reg;
    logic [ANGLE_W-1:0]        res_steer_reg;
    logic [SPEED_W-1:0]        res_speed_reg;

    logic                      good;
    logic                      div_start;
    logic [DN_W-1:0]           div_divisor;
    logic                      div_done;
    logic [DVD_W-1:0]          div_quot;

    logic [CW-1:0]             row_n;
    logic [PIX_W-1:0]          row_mx;
    logic [SUM_W-1:0]          row_sum;
    logic [WSUM_W-1:0]         row_wsum;

    logic signed [DER_W-1:0]   deriv;
    logic signed [PROP_W-1:0]  abs_prop;
    logic [PROP_W-1:0]         centring;
    logic signed [STEER_W-1:0] steer_sum;
    logic signed [STEER_W-1:0] steer_shr;
    logic [SPD_W:0]            speed_sum;

    assign {row_n, row_mx, row_sum, row_wsum} = row_data;

    assign good = !stopped_reg && (den_reg != '0);

    lcs_div #(
        .DVD_W (DVD_W),
        .DSR_W (DN_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend ({num_reg, {FRAC_BITS{1'b0}}}),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quot)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            BS_IDLE:     if (row_valid) state_next = BS_PREP1;
            BS_PREP1:    state_next = BS_PREP2;
            BS_PREP2:    state_next = BS_CHECK;
            BS_CHECK:    state_next = good ? BS_DIV_POS : BS_PUSH;
            BS_DIV_POS:  if (div_done) state_next = BS_DIV_FRAC;
            BS_DIV_FRAC: if (div_done) state_next = BS_MUL;
            BS_MUL:      state_next = BS_SUM;
            BS_SUM:      state_next = BS_PUSH;
            BS_PUSH:     if (!out_full) state_next = BS_IDLE;
            default:     state_next = BS_IDLE;
        endcase
    end

    always_comb
    begin
        row_pop     = (state_reg == BS_IDLE) && row_valid;
        div_start   = ((state_reg == BS_CHECK) && good)
                   || ((state_reg == BS_DIV_POS) && div_done);
        div_divisor = (state_reg == BS_CHECK) ? DN_W'(den_reg) : dn_reg;
        out_push    = (state_reg == BS_PUSH) && !out_full;
    end

    always_comb
    begin
        deriv     = DER_W'(prop_reg) - DER_W'(prev_prop_reg);
        abs_prop  = (prop_reg < 0) ? -prop_reg : prop_reg;
        centring  = HALF - $unsigned(abs_prop);
        steer_sum = STEER_W'(prod_p_reg) + STEER_W'(prod_d_reg);
        steer_shr = steer_sum >>> FRAC_BITS;
        speed_sum = (SPD_W+1)'(gains.base_speed) + (SPD_W+1)'(prod_s_reg >> FRAC_BITS);
    end

    assign out_data = {res_status_reg, res_pos_reg, res_steer_reg, res_speed_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BS_IDLE;
            prev_prop_reg <= '0;
            lost_reg      <= 1'b0;
            stopped_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if ((state_reg == BS_CHECK) && !stopped_reg && (den_reg == '0))
            begin
                if (lost_reg)
                begin
                    stopped_reg <= 1'b1;
                end
                lost_reg <= 1'b1;
            end
            if (state_reg == BS_MUL)
            begin
                prev_prop_reg <= prop_reg;
                lost_reg      <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            BS_IDLE:
            begin
                n_reg    <= row_n;
                mx_reg   <= row_mx;
                sum_reg  <= row_sum;
                wsum_reg <= row_wsum;
            end
            BS_PREP1:
            begin
                t1_reg  <= T1_W'(mx_reg) * T1_W'(n_reg);
                tri_reg <= TRI_W'((TRIP_W'(n_reg) * TRIP_W'(n_reg - 1'b1)) >> 1);
            end
            BS_PREP2:
            begin
                den_reg <= SUM_W'(t1_reg - T1_W'(sum_reg));
                num_reg <= WSUM_W'(mx_reg) * WSUM_W'(tri_reg) - wsum_reg;
            end
            BS_CHECK:
            begin
                dn_reg        <= DN_W'(den_reg) * DN_W'(n_reg);
                res_pos_reg   <= '0;
                res_steer_reg <= '0;
                res_speed_reg <= '0;
                if (stopped_reg || lost_reg)
                begin
                    res_status_reg <= ST_STOP;
                end
                else
                begin
                    res_status_reg <= ST_LOST;
                end
            end
            BS_DIV_POS:
            begin
                if (div_done)
                begin
                    res_pos_reg <= ((div_quot >> POS_W) != '0) ? POS_MAX : POS_W'(div_quot);
                end
            end
            BS_DIV_FRAC:
            begin
                // centroid over width stays below one, so the quotient fits the fraction
                prop_reg <= $signed(HALF) - $signed({1'b0, div_quot[FRAC_BITS-1:0]});
            end
            BS_MUL:
            begin
                prod_p_reg <= PRODP_W'($signed({1'b0, gains.steer_p_gain}))
                            * PRODP_W'(prop_reg);
                prod_d_reg <= PRODD_W'($signed({1'b0, gains.steer_d_gain}))
                            * PRODD_W'(deriv);
                prod_s_reg <= SPD_W'(gains.speed_gain) * SPD_W'(centring);
            end
            BS_SUM:
            begin
                res_status_reg <= ST_DRIVE;
                if (steer_shr > $signed(STEER_HI))
                begin
                    res_steer_reg <= ANGLE_W'(STEER_HI);
                end
                else if (steer_shr < $signed(STEER_LO))
                begin
                    res_steer_reg <= ANGLE_W'(STEER_LO);
                end
                else
                begin
                    res_steer_reg <= ANGLE_W'(steer_shr);
                end
                res_speed_reg <= (speed_sum > SPEED_HI) ? '1 : SPEED_W'(speed_sum);
            end
            BS_PUSH:
            begin
            end
            default:
            begin
            end
        endcase
    end

`ifndef SYNTHESIS
    a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == BS_DIV_POS || state_reg == BS_DIV_FRAC))
        else $error("divider finished outside a division state");

    a_stop_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        stopped_reg |=> stopped_reg)
        else $error("stop flag cleared");

    a_stop_status: assert property (@(posedge clk) disable iff (!rst_n)
        (out_push && stopped_reg) |-> (res_status_reg == ST_STOP))
        else $error("item pushed while stopped without stop status");

    a_idle_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_push && res_status_reg != ST_DRIVE)
            |-> (res_pos_reg == '0 && res_steer_reg == '0 && res_speed_reg == '0))
        else $error("non-drive item carries nonzero payload");
`endif

endmodule

`default_nettype wire

@@ rtl/core/line_centroid_steering.sv @@
// Processing: after a row's last pixel is taken, a good row runs two bit-serial divides;
// flat or stopped rows skip them and go straight to the output queue.
// Throughput: one pixel per cycle while the back end keeps up; the back end takes one
// row at a time from a two-row queue.
// Reset: asynchronous, active low; clears row accumulators, history, stop flag,
// both queues, and loads the default gains.
`default_nettype none

module line_centroid_steering #(
    parameter int MAX_WIDTH = 1024,
    parameter int FRAC_BITS = 8
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              push,
    output logic                                   full,
    input  wire logic [lcs_pkg::PIX_W-1:0]         pixel,
    input  wire logic                              last_in_row,
    output logic                                   empty,
    input  wire logic                              pop,
    output logic [lcs_pkg::STATUS_W-1:0]           status,
    output logic [lcs_pkg::POS_W-1:0]              line_position,
    output logic signed [lcs_pkg::ANGLE_W-1:0]     steering_angle,
    output logic [lcs_pkg::SPEED_W-1:0]            drive_speed,
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [lcs_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [lcs_pkg::CFG_W-1:0]         cfg_data
);
    import lcs_pkg::*;

    localparam int LG    = $clog2(MAX_WIDTH);
    localparam int CW    = $clog2(MAX_WIDTH + 1);
    localparam int ROW_W = PIX_W + CW + 2*PIX_W + 3*LG - 1;
    localparam int OUT_W = STATUS_W + POS_W + ANGLE_W + SPEED_W;

    gains_t            gains_reg;
    logic              accept;
    logic              row_push;
    logic [ROW_W-1:0]  row_wdata;
    logic [ROW_W-1:0]  row_rdata;
    logic              row_full;
    logic              row_empty;
    logic              row_pop;
    logic              out_push;
    logic              out_full;
    logic [OUT_W-1:0]  out_wdata;
    logic [OUT_W-1:0]  out_rdata;

    assign cfg_ready = 1'b1;
    assign full      = row_full;
    assign accept    = push && !row_full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gains_reg.speed_gain   <= SPEED_GAIN_RST;
            gains_reg.steer_p_gain <= STEER_P_GAIN_RST;
            gains_reg.steer_d_gain <= STEER_D_GAIN_RST;
            gains_reg.base_speed   <= BASE_SPEED_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_SPEED_GAIN:   gains_reg.speed_gain   <= cfg_data;
                REG_STEER_P_GAIN: gains_reg.steer_p_gain <= cfg_data;
                REG_STEER_D_GAIN: gains_reg.steer_d_gain <= cfg_data;
                REG_BASE_SPEED:   gains_reg.base_speed   <= cfg_data;
                default:          gains_reg              <= gains_reg;
            endcase
        end
    end

    lcs_front #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .pixel       (pixel),
        .last_in_row (last_in_row),
        .row_push    (row_push),
        .row_data    (row_wdata)
    );

    lcs_fifo #(
        .WIDTH (ROW_W),
        .DEPTH (2)
    ) u_row_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (row_push),
        .wr_data (row_wdata),
        .full    (row_full),
        .rd_en   (row_pop),
        .rd_data (row_rdata),
        .empty   (row_empty)
    );

    lcs_back #(
        .MAX_WIDTH (MAX_WIDTH),
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .gains     (gains_reg),
        .row_valid (!row_empty),
        .row_data  (row_rdata),
        .row_pop   (row_pop),
        .out_full  (out_full),
        .out_push  (out_push),
        .out_data  (out_wdata)
    );

    lcs_fifo #(
        .WIDTH (OUT_W),
        .DEPTH (2)
    ) u_out_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (out_push),
        .wr_data (out_wdata),
        .full    (out_full),
        .rd_en   (pop),
        .rd_data (out_rdata),
        .empty   (empty)
    );

    assign {status, line_position, steering_angle, drive_speed} = out_rdata;

endmodule

`default_nettype wire
